// File: rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared widths, types and codes for the direct-mapped cache tag lookup.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned LINES       = 128;
  localparam int unsigned OFFSET_W    = $clog2(BLOCK_BYTES);
  localparam int unsigned LINE_W      = $clog2(LINES);
  localparam int unsigned BLOCK_W     = ADDR_W - OFFSET_W;
  localparam int unsigned TAG_W       = BLOCK_W - LINE_W;
  localparam int unsigned COUNT_W     = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch address, start tag read
    logic commit;   // resolve lookup, update store, load result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } dp_status_t;

endpackage

// File: rtl/dmc_addr_if.sv
// ----------------------------------------------------------------------------
// dmc_addr_if
// Address channel: one byte address per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmc_addr_if;

  logic                        valid;
  logic                        ready;
  logic [dmc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);

endinterface

// File: rtl/dmc_result_if.sv
// ----------------------------------------------------------------------------
// dmc_result_if
// Result channel: decoded address, hit/miss outcome and running counts.
// ----------------------------------------------------------------------------
interface dmc_result_if;

  logic                          valid;
  logic                          ready;
  logic [dmc_pkg::OFFSET_W-1:0]  byte_offset;
  logic [dmc_pkg::BLOCK_W-1:0]   block_number;
  logic [dmc_pkg::LINE_W-1:0]    line_index;
  logic [dmc_pkg::TAG_W-1:0]     tag_value;
  logic                          miss;
  logic                          replaced;
  logic [dmc_pkg::TAG_W-1:0]     evicted_tag;
  logic [dmc_pkg::COUNT_W-1:0]   hit_count;
  logic [dmc_pkg::COUNT_W-1:0]   miss_count;

  modport source (
    output valid, output byte_offset, output block_number, output line_index,
    output tag_value, output miss, output replaced, output evicted_tag,
    output hit_count, output miss_count, input ready
  );
  modport sink (
    input valid, input byte_offset, input block_number, input line_index,
    input tag_value, input miss, input replaced, input evicted_tag,
    input hit_count, input miss_count, output ready
  );

endinterface

// File: rtl/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dmc_ctrl.sv
// ----------------------------------------------------------------------------
// dmc_ctrl
// Lookup sequencer: accept an address, then resolve it once the result
// register has room.
// ----------------------------------------------------------------------------
module dmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dmc_pkg::dp_status_t status,
  output dmc_pkg::ctrl_cmd_t  cmd
);

  dmc_pkg::state_t state_r;
  dmc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = dmc_pkg::ST_LOOKUP;
        end
      end
      dmc_pkg::ST_LOOKUP: begin
        // hold until the previous result has left
        if (status.out_free) begin
          state_nxt = dmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      dmc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dmc_pkg::ST_LOOKUP: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/dmc_datapath.sv
// ----------------------------------------------------------------------------
// dmc_datapath
// Address split, tag store with valid bits, tag compare, saturating
// counters and the result register.
// ----------------------------------------------------------------------------
module dmc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dmc_pkg::ADDR_W-1:0]  in_address,
  input  dmc_pkg::ctrl_cmd_t          cmd,
  output dmc_pkg::dp_status_t         status,
  dmc_result_if.source                out_chan
);

  localparam int unsigned OW = dmc_pkg::OFFSET_W;
  localparam int unsigned LW = dmc_pkg::LINE_W;
  localparam int unsigned TW = dmc_pkg::TAG_W;
  localparam int unsigned CW = dmc_pkg::COUNT_W;

  logic [dmc_pkg::ADDR_W-1:0]  addr_r;
  logic [dmc_pkg::LINES-1:0]   valid_r;
  logic [CW-1:0]               hit_cnt_r;
  logic [CW-1:0]               hit_cnt_nxt;
  logic [CW-1:0]               miss_cnt_r;
  logic [CW-1:0]               miss_cnt_nxt;
  logic                        out_valid_r;

  logic [OW-1:0]               offset;
  logic [dmc_pkg::BLOCK_W-1:0] block;
  logic [LW-1:0]               line;
  logic [TW-1:0]               tag;
  logic [TW-1:0]               stored_tag;
  logic                        line_valid;
  logic                        hit;
  logic                        fill;

  // lookup index of the incoming address goes straight to the read port
  dmc_ram #(
    .WIDTH (TW),
    .DEPTH (dmc_pkg::LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (fill),
    .waddr (line),
    .wdata (tag),
    .re    (cmd.capture),
    .raddr (in_address[OW +: LW]),
    .rdata (stored_tag)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= in_address;
    end
  end

  assign offset     = addr_r[OW-1:0];
  assign block      = addr_r[dmc_pkg::ADDR_W-1:OW];
  assign line       = addr_r[OW +: LW];
  assign tag        = addr_r[dmc_pkg::ADDR_W-1:OW+LW];
  assign line_valid = valid_r[line];
  assign hit        = line_valid && (stored_tag == tag);
  assign fill       = cmd.commit && !hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (fill) begin
      valid_r[line] <= 1'b1;
    end
  end

  // counters stop at all ones
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (cmd.commit) begin
      if (hit) begin
        if (hit_cnt_r != dmc_pkg::COUNT_MAX) begin
          hit_cnt_nxt = hit_cnt_r + CW'(1);
        end
      end else begin
        if (miss_cnt_r != dmc_pkg::COUNT_MAX) begin
          miss_cnt_nxt = miss_cnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_chan.byte_offset  <= offset;
      out_chan.block_number <= block;
      out_chan.line_index   <= line;
      out_chan.tag_value    <= tag;
      out_chan.miss         <= !hit;
      out_chan.replaced     <= line_valid && !hit;
      out_chan.evicted_tag  <= (line_valid && !hit) ? stored_tag : '0;
      out_chan.hit_count    <= hit_cnt_nxt;
      out_chan.miss_count   <= miss_cnt_nxt;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign status.out_free = !out_valid_r || out_chan.ready;

endmodule

// File: rtl/direct_mapped_cache_tag_lookup_unit.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_lookup_unit
// Direct-mapped tag lookup: 128 lines of 32-byte blocks, 20-bit tags.
// ----------------------------------------------------------------------------
// Each address passes through a tag read, through the tag store's registered
// read port, and then a compare step that updates the store and counters and
// loads the result register. The unit takes no new address until the current
// one has been resolved; a finished result waits in the result register while
// the next address is taken and read, and the compare stage holds until the
// register is free. Valid bits live in flip-flops cleared by reset, so the
// unit is ready as soon as reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_lookup_unit (
  input  logic         clk,
  input  logic         rst_n,
  dmc_addr_if.sink     in_chan,
  dmc_result_if.source out_chan
);

  dmc_pkg::ctrl_cmd_t  cmd;
  dmc_pkg::dp_status_t status;
  logic                in_ready;

  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dmc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_address (in_chan.address),
    .cmd        (cmd),
    .status     (status),
    .out_chan   (out_chan)
  );

  assign in_chan.ready = in_ready;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the direct-mapped cache tag lookup unit: drives byte addresses,
// keeps its own copy of the valid bits, tags and hit/miss counts, and checks
// every decoded result, in order, against that copy, with stalls inserted on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [BLOCK_W-1:0]  block_number;
    logic [LINE_W-1:0]   line_index;
    logic [TAG_W-1:0]    tag_value;
    logic                miss;
    logic                replaced;
    logic [TAG_W-1:0]    evicted_tag;
    logic [COUNT_W-1:0]  hit_count;
    logic [COUNT_W-1:0]  miss_count;
  } lookup_result_t;

  logic clk;
  logic rst_n;

  dmc_addr_if   in_if ();
  dmc_result_if out_if ();

  direct_mapped_cache_tag_lookup_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow of the tag store and counters
  logic [LINES-1:0]   line_valid;
  logic [TAG_W-1:0]   line_tag [LINES];
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] miss_total;

  lookup_result_t pending_lookups [$];
  int unsigned    mismatch_count;
  bit             steady_mode;
  int unsigned    hold_off_request;
  logic [TAG_W-1:0] tag_pool [4];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic lookup_result_t resolve_lookup(input logic [ADDR_W-1:0] address);
    lookup_result_t r;
    r              = '0;
    r.byte_offset  = address[OFFSET_W-1:0];
    r.block_number = address[ADDR_W-1:OFFSET_W];
    r.line_index   = r.block_number[LINE_W-1:0];
    r.tag_value    = r.block_number[BLOCK_W-1:LINE_W];
    if (line_valid[r.line_index] && line_tag[r.line_index] == r.tag_value) begin
      if (hit_total != COUNT_MAX) hit_total++;
    end else begin
      if (miss_total != COUNT_MAX) miss_total++;
      r.miss = 1'b1;
      if (line_valid[r.line_index]) begin
        r.replaced    = 1'b1;
        r.evicted_tag = line_tag[r.line_index];
      end
      line_valid[r.line_index] = 1'b1;
      line_tag[r.line_index]   = r.tag_value;
    end
    r.hit_count  = hit_total;
    r.miss_count = miss_total;
    return r;
  endfunction

  function automatic string describe(input lookup_result_t r);
    return $sformatf("off=%0d blk=%h line=%0d tag=%h miss=%b repl=%b evict=%h hits=%0d misses=%0d",
                     r.byte_offset, r.block_number, r.line_index, r.tag_value, r.miss,
                     r.replaced, r.evicted_tag, r.hit_count, r.miss_count);
  endfunction

  // Mostly a few recurring tags, half of the time over a narrow band of lines,
  // so hits and evictions are common; the rest is fully random.
  function automatic logic [ADDR_W-1:0] random_address();
    logic [TAG_W-1:0]    tag;
    logic [LINE_W-1:0]   line;
    logic [OFFSET_W-1:0] offs;
    if ($urandom_range(0, 9) < 2) return $urandom;
    tag  = tag_pool[$urandom_range(0, 3)];
    line = ($urandom_range(0, 1) != 0) ? LINE_W'($urandom_range(0, 15)) : LINE_W'($urandom);
    offs = OFFSET_W'($urandom);
    return {tag, line, offs};
  endfunction

  // Valid stays high from one transfer to the next unless a gap is taken
  task automatic send_address(input logic [ADDR_W-1:0] address);
    int unsigned gap;
    gap = steady_mode ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.address <= address;
    do @(posedge clk); while (!in_if.ready);
    pending_lookups.push_back(resolve_lookup(address));
  endtask

  task automatic pause_sender();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  task automatic test_directed_edges();
    logic [ADDR_W-1:0] addrs [17];
    addrs = '{32'h0000_0000,   // cold miss, line 0, tag 0
              32'h0000_001F,   // hit, top offset
              32'hFFFF_FFFF,   // cold miss, last line, top tag
              32'hFFFF_FFE0,   // hit, offset 0
              32'h0000_0FE0,   // last line, tag 0: evicts top tag
              32'hFFFF_F000,   // line 0, top tag: evicts tag 0
              32'h0000_0000,   // evicts top tag back
              32'h0000_0000,
              32'hAAAA_AAAA,
              32'h5555_5555,
              32'hAAAA_AAA0,
              32'h5555_555F,
              32'h0000_0020,   // line 1
              32'h8000_0020,   // line 1, tag MSB only
              32'h0000_0020,
              32'h0000_0FFF,
              32'h0000_0FE1};
    foreach (addrs[i]) send_address(addrs[i]);
  endtask

  task automatic test_steady_stream();
    steady_mode = 1'b1;
    repeat (120) send_address(random_address());
    steady_mode = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering until the unit stalls
  task automatic test_output_backpressure();
    // drop valid while waiting for the receiver to start holding off
    in_if.valid      <= 1'b0;
    hold_off_request = 80;
    do @(posedge clk); while (hold_off_request != 0);
    steady_mode = 1'b1;
    repeat (30) send_address(random_address());
    steady_mode = 1'b0;
  endtask

  task automatic test_sender_drain_pause();
    repeat (3) begin
      repeat (20) send_address(random_address());
      pause_sender();
    end
  endtask

  task automatic test_random_traffic();
    repeat (1080) send_address(random_address());
  endtask

  task automatic finish_run();
    steady_mode = 1'b1;
    pause_sender();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  endtask

  // Result receiver
  initial begin : result_drain
    int unsigned span;
    logic        level;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_request != 0) begin
        level            = 1'b0;
        span             = hold_off_request;
        hold_off_request = 0;
      end else if (steady_mode) begin
        level = 1'b1;
        span  = 1;
      end else begin
        level = ($urandom_range(0, 99) < 70);
        span  = 1 + pick_gap();
      end
      out_if.ready <= level;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    lookup_result_t seen;
    lookup_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.byte_offset  = out_if.byte_offset;
      seen.block_number = out_if.block_number;
      seen.line_index   = out_if.line_index;
      seen.tag_value    = out_if.tag_value;
      seen.miss         = out_if.miss;
      seen.replaced     = out_if.replaced;
      seen.evicted_tag  = out_if.evicted_tag;
      seen.hit_count    = out_if.hit_count;
      seen.miss_count   = out_if.miss_count;
      if (pending_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("tb: result with no lookup pending: %s", describe(seen));
      end else begin
        want = pending_lookups.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("tb: mismatch");
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(seen));
          end
        end
      end
    end
  end

  initial begin
    line_valid       = '0;
    hit_total        = '0;
    miss_total       = '0;
    mismatch_count   = 0;
    steady_mode      = 1'b0;
    hold_off_request = 0;
    foreach (line_tag[i]) line_tag[i] = '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_W'($urandom);
    tag_pool[3] = TAG_W'($urandom);

    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.address <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_steady_stream();
    test_output_backpressure();
    test_sender_drain_pause();
    test_random_traffic();
    finish_run();
  end

endmodule

// File: files.f
rtl/dmc_pkg.sv
rtl/dmc_addr_if.sv
rtl/dmc_result_if.sv
rtl/dmc_ram.sv
rtl/dmc_ctrl.sv
rtl/dmc_datapath.sv
rtl/direct_mapped_cache_tag_lookup_unit.sv
bench/tb.sv
